// ===== hw/rtl/dle_byte_stuffing_framer_assert.svh =====
// assertion macros for the dle byte stuffing framer checker
// depends on a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef DLE_BYTE_STUFFING_FRAMER_ASSERT_SVH
`define DLE_BYTE_STUFFING_FRAMER_ASSERT_SVH

// property checked while out of reset
`define DBSF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define DBSF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/dbsf_pkg.sv =====
// shared constants and types for the dle byte stuffing framer
// no dependencies
package dbsf_pkg;

    // line control symbols
    localparam logic [7:0] SYM_DLE = 8'h10;
    localparam logic [7:0] SYM_STX = 8'h02;
    localparam logic [7:0] SYM_ETX = 8'h03;

    // fixed slot layout of the bytes one item can cause
    localparam int NUM_SLOTS   = 7;
    localparam int SLOT_H_DLE  = 0;
    localparam int SLOT_H_STX  = 1;
    localparam int SLOT_STUFF  = 2;
    localparam int SLOT_DATA   = 3;
    localparam int SLOT_T_DLE  = 4;
    localparam int SLOT_T_ETX  = 5;
    localparam int SLOT_BCC    = 6;

    typedef logic [NUM_SLOTS-1:0] t_slot_mask;
    typedef logic [7:0]           t_byte;

endpackage

// ===== hw/rtl/dle_byte_stuffing_framer.sv =====
// An accepted item waits in the pending slot mask; its first line byte then moves to the
// output byte register. Throughput: one line byte per cycle while the line side is ready,
// set by the single output register; an item causes 1 to 7 bytes, two or more for a DLE.
// A new item is taken while the last byte of the previous one moves out.
// Reset (synchronous, active low) clears the pending slots, output valid, in-frame, check.
// top level of the dle stx/etx byte stuffing framer with xor block check
// depends on dbsf_pkg
module dle_byte_stuffing_framer
    import dbsf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input item stream
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] payload_byte
    input  logic       i_s_tlast,   // last_byte
    // line byte stream
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] line_byte
    output logic       o_m_tlast    // end_of_run
);

    // pending item: slot mask, data byte and closing check byte
    t_slot_mask r_mask, n_mask;
    t_byte      r_data, n_data;
    t_byte      r_bcc, n_bcc;
    // frame state
    logic       r_in_frame, n_in_frame;
    t_byte      r_check, n_check;
    // output register
    logic       r_out_valid, n_out_valid;
    t_byte      r_out_byte, n_out_byte;
    logic       r_out_last, n_out_last;

    logic       out_free;
    logic       move;
    logic       accept;
    t_slot_mask sel;
    t_slot_mask rest;
    t_byte      slot_byte [NUM_SLOTS];
    t_byte      sel_byte;
    t_byte      acc_check;
    t_slot_mask acc_mask;

    // output handshake and slot selection
    assign out_free   = !r_out_valid || i_m_tready;
    assign move       = (r_mask != '0) && out_free;
    assign sel        = r_mask & (~r_mask + t_slot_mask'(1));
    assign rest       = r_mask & ~sel;
    assign o_s_tready = (r_mask == '0) || (move && (rest == '0));
    assign accept     = i_s_tvalid && o_s_tready;

    // bytes of each slot
    always_comb begin
        slot_byte[SLOT_H_DLE] = SYM_DLE;
        slot_byte[SLOT_H_STX] = SYM_STX;
        slot_byte[SLOT_STUFF] = SYM_DLE;
        slot_byte[SLOT_DATA]  = r_data;
        slot_byte[SLOT_T_DLE] = SYM_DLE;
        slot_byte[SLOT_T_ETX] = SYM_ETX;
        slot_byte[SLOT_BCC]   = r_bcc;
    end

    // one-hot byte mux
    always_comb begin
        sel_byte = '0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (sel[k]) begin
                sel_byte = sel_byte | slot_byte[k];
            end
        end
    end

    // slots and check update for an incoming item
    always_comb begin
        acc_check = (r_in_frame ? r_check : '0) ^ i_s_tdata;
        acc_mask = '0;
        acc_mask[SLOT_H_DLE] = !r_in_frame;
        acc_mask[SLOT_H_STX] = !r_in_frame;
        acc_mask[SLOT_STUFF] = (i_s_tdata == SYM_DLE);
        acc_mask[SLOT_DATA]  = 1'b1;
        acc_mask[SLOT_T_DLE] = i_s_tlast;
        acc_mask[SLOT_T_ETX] = i_s_tlast;
        acc_mask[SLOT_BCC]   = i_s_tlast;
    end

    // next state
    always_comb begin
        n_mask      = move ? rest : r_mask;
        n_data      = r_data;
        n_bcc       = r_bcc;
        n_in_frame  = r_in_frame;
        n_check     = r_check;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        if (move) begin
            n_out_valid = 1'b1;
            n_out_byte  = sel_byte;
            n_out_last  = (rest == '0);
        end
        if (accept) begin
            n_mask     = acc_mask;
            n_data     = i_s_tdata;
            n_bcc      = acc_check ^ SYM_ETX;
            n_in_frame = !i_s_tlast;
            n_check    = i_s_tlast ? '0 : acc_check;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_in_frame  <= 1'b0;
            r_check     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask      <= n_mask;
            r_in_frame  <= n_in_frame;
            r_check     <= n_check;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_data     <= n_data;
        r_bcc      <= n_bcc;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;

endmodule

// ===== hw/rtl/dbsf_checker.sv =====
// port-level checker for the dle byte stuffing framer, bound to the top level
// depends on dle_byte_stuffing_framer_assert.svh
`include "dle_byte_stuffing_framer_assert.svh"

module dbsf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic [7:0] i_s_tdata,
    input logic       i_s_tlast,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast
);

    // a stalled line byte holds
    `DBSF_ASSERT(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast), "line byte changed while stalled")

    // reset leaves no line byte pending
    `DBSF_ASSERT_ALWAYS(a_rst_clear, !i_rst_n |=> !o_m_tvalid, "line byte valid after reset")

    // within an item the bytes keep coming
    `DBSF_ASSERT(a_run_cont, o_m_tvalid && !o_m_tlast |=> o_m_tvalid, "gap inside an item's bytes")

    // an accepted item leads to a valid line byte behind the slot mask and output registers
    `DBSF_ASSERT(a_item_out, i_s_tvalid && o_s_tready |=> ##1 o_m_tvalid, "accepted item caused no line byte")

endmodule

bind dle_byte_stuffing_framer dbsf_checker u_dbsf_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// testbench for dle_byte_stuffing_framer: a directed table of frames, then random frames,
// with every line item checked against hand-written bytes or an in-bench framing and block check predictor
// depends on dbsf_pkg and dle_byte_stuffing_framer
module tb_top;
    import dbsf_pkg::*;

    // one expected line item
    typedef struct {
        t_byte line;
        logic  eor;
    } t_line_item;

    // one directed row; n_typed > 0 means the line bytes are written out by hand,
    // first byte in the top bits of typed
    typedef struct {
        t_byte       payload;
        logic        last;
        int          n_typed;
        logic [55:0] typed;
    } t_plan_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata = 8'h00;   // [7:0] payload_byte
    logic       i_s_tlast = 1'b0;    // last_byte
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;           // [7:0] line_byte
    logic       o_m_tlast;           // end_of_run

    // predictor state: open frame flag and running xor of its payload
    logic       frame_open = 1'b0;
    t_byte      frame_check = 8'h00;

    t_line_item line_bytes_due[$];
    t_plan_row  plan[$];
    int         n_errors = 0;
    bit         snd_steady = 1'b0;
    bit         rcv_steady = 1'b0;

    dle_byte_stuffing_framer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // frame one payload byte and queue the line items it causes
    task automatic expect_line_bytes(input t_byte payload, input logic last,
                                     input int n_typed, input logic [55:0] typed);
        t_byte      seq[$];
        t_line_item li;
        int         k;
        if (!frame_open) begin
            seq.push_back(SYM_DLE);
            seq.push_back(SYM_STX);
            frame_open = 1'b1;
            frame_check = 8'h00;
        end
        // a dle in the payload goes out twice, but counts once in the check
        if (payload == SYM_DLE)
            seq.push_back(SYM_DLE);
        seq.push_back(payload);
        frame_check = frame_check ^ payload;
        // trailer: the check byte includes etx
        if (last) begin
            seq.push_back(SYM_DLE);
            seq.push_back(SYM_ETX);
            seq.push_back(frame_check ^ SYM_ETX);
            frame_open = 1'b0;
            frame_check = 8'h00;
        end
        if (n_typed > 0) begin
            seq.delete();
            for (k = 0; k < n_typed; k++)
                seq.push_back(typed[55-8*k -: 8]);
        end
        for (k = 0; k < seq.size(); k++) begin
            li.line = seq[k];
            li.eor = (k == seq.size() - 1);
            line_bytes_due.push_back(li);
        end
    endtask

    // offer one item after a random gap and wait for it to be taken
    task automatic send_item(input t_byte payload, input logic last,
                             input int n_typed, input logic [55:0] typed);
        int gap;
        gap = snd_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= payload;
        i_s_tlast <= last;
        do @(posedge i_clk); while (!o_s_tready);
        expect_line_bytes(payload, last, n_typed, typed);
    endtask

    task automatic add_row(input t_byte payload, input logic last,
                           input int n_typed, input logic [55:0] typed);
        t_plan_row r;
        r.payload = payload;
        r.last = last;
        r.n_typed = n_typed;
        r.typed = typed;
        plan.push_back(r);
    endtask

    // payloads lean toward the control symbols
    function automatic t_byte pick_payload();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return SYM_DLE;
        if (r < 26) return SYM_STX;
        if (r < 32) return SYM_ETX;
        if (r < 36) return 8'h00;
        if (r < 40) return 8'hFF;
        return t_byte'($urandom_range(0, 255));
    endfunction

    function automatic int pick_frame_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 4);
        if (r < 92) return $urandom_range(5, 12);
        return $urandom_range(13, 40);
    endfunction

    // line side: random stalls, check each taken item against the oldest expectation
    initial begin
        int         stall;
        int         n_taken;
        t_line_item want;
        n_taken = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (n_taken % 16 == 0)
                rcv_steady = ($urandom_range(0, 3) == 0);
            stall = rcv_steady ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            n_taken++;
            if (line_bytes_due.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected line item: expected none, got %h last %b",
                         $time, o_m_tdata, o_m_tlast);
            end else begin
                want = line_bytes_due.pop_front();
                if (o_m_tdata !== want.line || o_m_tlast !== want.eor) begin
                    n_errors++;
                    $display("%0t: line item mismatch: expected %h last %b, got %h last %b",
                             $time, want.line, want.eor, o_m_tdata, o_m_tlast);
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        int n_sent;
        int len;
        int k;
        int drain;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single byte frames: header, byte and trailer from one item
        add_row(8'h00, 1'b1, 6, {SYM_DLE, SYM_STX, 8'h00, SYM_DLE, SYM_ETX, 8'h03, 8'h00});
        add_row(8'hFF, 1'b1, 6, {SYM_DLE, SYM_STX, 8'hFF, SYM_DLE, SYM_ETX, 8'hFC, 8'h00});
        // worst case: a dle that opens and closes a frame
        add_row(SYM_DLE, 1'b1, 7, {SYM_DLE, SYM_STX, SYM_DLE, SYM_DLE, SYM_DLE, SYM_ETX, 8'h13});
        add_row(SYM_STX, 1'b1, 6, {SYM_DLE, SYM_STX, SYM_STX, SYM_DLE, SYM_ETX, 8'h01, 8'h00});
        add_row(SYM_ETX, 1'b1, 6, {SYM_DLE, SYM_STX, SYM_ETX, SYM_DLE, SYM_ETX, 8'h00, 8'h00});
        // multi byte frame with stuffed dles
        add_row(SYM_DLE, 1'b0, 4, {SYM_DLE, SYM_STX, SYM_DLE, SYM_DLE, 24'h0});
        add_row(SYM_DLE, 1'b0, 2, {SYM_DLE, SYM_DLE, 40'h0});
        add_row(8'h55, 1'b0, 1, {8'h55, 48'h0});
        add_row(8'hAA, 1'b1, 0, '0);
        // bit walk through a longer frame
        add_row(8'h01, 1'b0, 0, '0);
        add_row(8'h80, 1'b0, 0, '0);
        add_row(8'h7F, 1'b0, 0, '0);
        add_row(8'hFE, 1'b0, 0, '0);
        add_row(SYM_STX, 1'b0, 0, '0);
        add_row(SYM_ETX, 1'b0, 0, '0);
        add_row(8'h00, 1'b0, 0, '0);
        add_row(SYM_DLE, 1'b1, 0, '0);
        // back to back frames
        add_row(8'h5A, 1'b1, 0, '0);
        add_row(8'hA5, 1'b0, 0, '0);
        add_row(8'hC3, 1'b1, 0, '0);

        for (k = 0; k < plan.size(); k++)
            send_item(plan[k].payload, plan[k].last, plan[k].n_typed, plan[k].typed);

        // hold off until the line side has caught up
        i_s_tvalid <= 1'b0;
        while (line_bytes_due.size() > 0) @(posedge i_clk);

        // random frames
        n_sent = 0;
        while (n_sent < 240) begin
            snd_steady = ($urandom_range(0, 3) == 0);
            len = pick_frame_len();
            for (k = 0; k < len; k++)
                send_item(pick_payload(), k == len - 1, 0, '0);
            n_sent += len;
            if ($urandom_range(0, 9) == 0) begin
                i_s_tvalid <= 1'b0;
                while (line_bytes_due.size() > 0) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b0;

        // drain, then let the bench idle to catch stray items
        drain = 0;
        while (line_bytes_due.size() > 0 && drain < 5000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (10) @(posedge i_clk);
        if (line_bytes_due.size() > 0) begin
            n_errors++;
            $display("%0t: %0d line items never came: expected %h last %b, got none",
                     $time, line_bytes_due.size(), line_bytes_due[0].line,
                     line_bytes_due[0].eor);
        end

        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
